>>> design/u2u_pkg.sv
`default_nettype none

package u2u_pkg;

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_LOW    = 2'd2,
    PH_HIGH   = 2'd3
  } phase_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ODD  = 2'd1,
    ST_MODE = 2'd2
  } status_e;

  localparam logic [7:0]  BomLo     = 8'hFF;
  localparam logic [7:0]  BomHi     = 8'hFE;
  localparam logic [15:0] Lim1Byte  = 16'h0080;
  localparam logic [15:0] Lim2Byte  = 16'h0800;
  localparam logic [7:0]  Lead2     = 8'hC0;
  localparam logic [7:0]  Lead3     = 8'hE0;
  localparam logic [7:0]  ContMark  = 8'h80;
  localparam int          MaxResults = 3;

  typedef struct packed {
    phase_e     phase;
    logic [7:0] held;
    logic       comp;
    status_e    fault;
  } conv_state_t;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       tend;
    status_e    status;
  } result_t;

  typedef struct packed {
    logic [1:0]      cnt;
    logic [2:0][7:0] bytes;
  } enc_t;

  // UTF-8 encoding of one 16-bit code unit, surrogates included as plain
  // three-byte sequences.
  function automatic enc_t encode_unit(input logic [15:0] unit);
    enc_t e;
    e.bytes = '0;
    if (unit < Lim1Byte) begin
      e.cnt      = 2'd1;
      e.bytes[0] = unit[7:0];
    end else if (unit < Lim2Byte) begin
      e.cnt      = 2'd2;
      e.bytes[0] = Lead2 | {3'b000, unit[10:6]};
      e.bytes[1] = ContMark | {2'b00, unit[5:0]};
    end else begin
      e.cnt      = 2'd3;
      e.bytes[0] = Lead3 | {4'b0000, unit[15:12]};
      e.bytes[1] = ContMark | {2'b00, unit[11:6]};
      e.bytes[2] = ContMark | {2'b00, unit[5:0]};
    end
    return e;
  endfunction

endpackage

`default_nettype wire

>>> design/u2u_encoder.sv
`default_nettype none

module u2u_encoder
  import u2u_pkg::*;
(
  input  var conv_state_t          state_i,
  input  wire logic [7:0]          byte_i,
  input  wire logic                last_i,
  output conv_state_t              state_o,
  output result_t [MaxResults-1:0] res_o,
  output logic [1:0]               cnt_o
);

  enc_t        enc;
  logic        do_enc;
  logic [15:0] unit;
  status_e     status;
  conv_state_t nxt;
  logic [1:0]  n;
  logic [1:0]  last_idx;

  always_comb begin
    nxt      = state_i;
    do_enc   = 1'b0;
    status   = ST_OK;
    unit     = {byte_i, state_i.held};
    n        = 2'd0;
    last_idx = 2'd0;
    res_o    = '0;

    case (state_i.phase)
      PH_FIRST: begin
        nxt.held  = byte_i;
        nxt.phase = PH_SECOND;
        status    = ST_ODD;
      end
      PH_SECOND: begin
        if (state_i.held == BomLo && byte_i == BomHi) begin
          nxt.comp = 1'b1;
        end else begin
          do_enc = 1'b1;
        end
        nxt.phase = PH_LOW;
      end
      PH_LOW: begin
        if (state_i.comp) begin
          // Compressed text: each byte is a code point; a zero byte latches a fault.
          if (state_i.fault == ST_OK) begin
            if (byte_i == 8'h00) begin
              nxt.fault = ST_MODE;
            end else begin
              do_enc = 1'b1;
              unit   = {8'h00, byte_i};
            end
          end
        end else begin
          nxt.held  = byte_i;
          nxt.phase = PH_HIGH;
          status    = ST_ODD;
        end
      end
      PH_HIGH: begin
        do_enc    = 1'b1;
        nxt.phase = PH_LOW;
      end
      default: begin
        nxt = state_i;
      end
    endcase

    enc = encode_unit(unit);
    if (do_enc) begin
      n = enc.cnt;
      for (int i = 0; i < MaxResults; i++) begin
        res_o[i].data  = enc.bytes[i];
        res_o[i].valid = 1'b1;
      end
    end

    if (last_i) begin
      if (nxt.fault != ST_OK) begin
        status = nxt.fault;
      end
      if (status != ST_OK || n == 2'd0) begin
        // Bare end marker carrying the status.
        res_o        = '0;
        res_o[0].tend   = 1'b1;
        res_o[0].status = status;
        n = 2'd1;
      end else begin
        last_idx = n - 2'd1;
        res_o[last_idx].tend = 1'b1;
      end
      nxt = '{phase: PH_FIRST, held: 8'h00, comp: 1'b0, fault: ST_OK};
    end

    state_o = nxt;
    cnt_o   = n;
  end

endmodule

`default_nettype wire

>>> design/ucs2le_to_utf8_stream_converter_unit.sv
`default_nettype none
// The first UTF-8 byte of an input transaction is offered in the cycle after it is taken.
// Each input byte yields n = 0..3 results; the byte-wide result channel drains them from
// the three-entry result buffer, and input is stalled until the buffer drains.
// A new input is taken in the same cycle the last buffered result leaves.
// Reset (rst_ni low, asynchronous) empties the buffer and returns the decoder to the
// start of a text.

module ucs2le_to_utf8_stream_converter_unit
  import u2u_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] in_byte
  input  wire logic       s_axis_tlast_i,   // in_last
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_byte
  output logic [2:0]      m_axis_tuser_o,   // [0] byte_valid, [2:1] status
  output logic            m_axis_tlast_o    // text_end
);

  conv_state_t              state_q, state_d;
  result_t [MaxResults-1:0] res_d;
  result_t [MaxResults-1:0] buf_q, buf_d;
  logic [1:0]               cnt_q, cnt_d;
  logic [1:0]               enc_cnt;
  logic                     in_acc;
  logic                     out_acc;

  u2u_encoder u_encoder (
    .state_i (state_q),
    .byte_i  (s_axis_tdata_i),
    .last_i  (s_axis_tlast_i),
    .state_o (state_d),
    .res_o   (res_d),
    .cnt_o   (enc_cnt)
  );

  assign out_acc         = m_axis_tvalid_o && m_axis_tready_i;
  assign s_axis_tready_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && m_axis_tready_i);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;

  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (in_acc) begin
      buf_d = res_d;
      cnt_d = enc_cnt;
    end else if (out_acc) begin
      buf_d[0] = buf_q[1];
      buf_d[1] = buf_q[2];
      cnt_d    = cnt_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '{phase: PH_FIRST, held: 8'h00, comp: 1'b0, fault: ST_OK};
      cnt_q   <= 2'd0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign m_axis_tvalid_o = (cnt_q != 2'd0);
  assign m_axis_tdata_o  = buf_q[0].data;
  assign m_axis_tuser_o  = {buf_q[0].status, buf_q[0].valid};
  assign m_axis_tlast_o  = buf_q[0].tend;

endmodule

`default_nettype wire
